// File: sv/tlps_pkg.sv
// shared types and constants for the traffic light pedestrian sequencer
`default_nettype none

package tlps_pkg;

  // period length register
  localparam int unsigned PeriodWidth = 8;
  localparam logic [PeriodWidth-1:0] PeriodReset = 8'd20;

  // light phases, in sequence order
  typedef enum logic [1:0] {
    PhGreen   = 2'd0,
    PhYToRed  = 2'd1,
    PhRed     = 2'd2,
    PhYToGreen = 2'd3
  } phase_e;

  // pedestrian request level
  typedef enum logic [1:0] {
    ReqIdle    = 2'd0,
    ReqPending = 2'd1,
    ReqDone    = 2'd2
  } req_e;

  // one lamp word
  typedef struct packed {
    logic car_green;
    logic car_yellow;
    logic car_red;
    logic ped_green;
    logic ped_yellow;
    logic ped_red;
  } lamps_t;

endpackage

`default_nettype wire

// File: sv/tlps_seq.sv
// phase sequencer: period counter, request handling and lamp decode per tick
`default_nettype none

module tlps_seq
  import tlps_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH = 8
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   cfg_we_i,
  input  wire logic [PeriodWidth-1:0] cfg_wdata_i,
  input  wire logic                   step_i,
  input  wire logic                   press_i,
  output lamps_t                      lamps_o
);

  localparam int unsigned ExtW = 17;
  localparam logic [ExtW-1:0] CountMax = ExtW'((1 << COUNT_WIDTH) - 1);
  localparam logic [COUNT_WIDTH-1:0] CountOne = COUNT_WIDTH'(1);

  logic [PeriodWidth-1:0] period_q;
  phase_e                 phase_q, phase_d;
  phase_e                 act_q, act_d;
  req_e                   req_q, req_d;
  logic [COUNT_WIDTH-1:0] ticks_q, ticks_d;
  logic                   blink_q, blink_d;

  logic [ExtW-1:0]        len_ext;
  logic [COUNT_WIDTH-1:0] load_len;

  // period length: zero runs one tick, long lengths saturate to the counter range
  always_comb begin
    len_ext = ExtW'(period_q);
    if (len_ext == '0) begin
      len_ext = ExtW'(1);
    end
    if (len_ext > CountMax) begin
      len_ext = CountMax;
    end
    load_len = len_ext[COUNT_WIDTH-1:0];
  end

  // next state for one tick
  always_comb begin
    phase_d = phase_q;
    act_d   = act_q;
    req_d   = req_q;
    ticks_d = ticks_q;
    blink_d = blink_q;
    // new period
    if (ticks_q == '0) begin
      if (req_q == ReqIdle) begin
        phase_d = phase_e'(phase_q + 2'd1);
      end
      if (req_q == ReqDone) begin
        req_d = ReqIdle;
      end
      act_d   = phase_d;
      ticks_d = load_len;
      blink_d = 1'b0;
    end
    // latch a press
    if (press_i && req_d == ReqIdle) begin
      req_d = ReqPending;
    end
    // count down and handle a pending request
    case (act_d)
      PhGreen: begin
        ticks_d = ticks_d - CountOne;
        if (req_d == ReqPending) begin
          req_d   = ReqDone;
          phase_d = PhYToRed;
          ticks_d = '0;
        end
      end
      PhRed: begin
        ticks_d = ticks_d - CountOne;
        if (req_d == ReqPending) begin
          req_d   = ReqDone;
          phase_d = PhYToGreen;
          ticks_d = load_len;
        end
      end
      default: begin
        blink_d = ~blink_d;
        ticks_d = ticks_d - CountOne;
        if (req_d == ReqPending) begin
          req_d   = ReqDone;
          phase_d = PhRed;
          ticks_d = load_len;
        end
      end
    endcase
  end

  // lamp decode for the running period
  always_comb begin
    lamps_o = '0;
    case (act_d)
      PhGreen: begin
        lamps_o.car_green = 1'b1;
        lamps_o.ped_red   = 1'b1;
      end
      PhRed: begin
        lamps_o.car_red   = 1'b1;
        lamps_o.ped_green = 1'b1;
      end
      default: begin
        lamps_o.car_yellow = blink_d;
        lamps_o.ped_yellow = blink_d;
      end
    endcase
  end

  // period length register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= PeriodReset;
    end else if (cfg_we_i) begin
      period_q <= cfg_wdata_i;
    end
  end

  // sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhGreen;
      act_q   <= PhGreen;
      req_q   <= ReqIdle;
      ticks_q <= '0;
      blink_q <= 1'b0;
    end else if (step_i) begin
      phase_q <= phase_d;
      act_q   <= act_d;
      req_q   <= req_d;
      ticks_q <= ticks_d;
      blink_q <= blink_d;
    end
  end

endmodule

`default_nettype wire

// File: sv/tlps_out.sv
// output register for the lamp word with valid/ready handshake
`default_nettype none

module tlps_out
  import tlps_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   load_i,
  input  wire lamps_t lamps_i,
  input  wire logic   out_ready_i,
  output logic        out_valid_o,
  output logic        free_o,
  output lamps_t      lamps_o
);

  logic   valid_q, valid_d;
  lamps_t lamps_q;

  // register can take a new word when empty or being drained
  assign free_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      lamps_q <= lamps_i;
    end
  end

  assign out_valid_o = valid_q;
  assign lamps_o     = lamps_q;

endmodule

`default_nettype wire

// File: sv/traffic_light_pedestrian_sequencer.sv
// top level of the traffic light pedestrian sequencer
// the lamp word for a tick is registered and valid in the cycle after the tick is accepted
// one tick per cycle if not stalled; the single output register refills as it drains
// the tick logic is one pass of the sequencer between its state and the output register
// reset: asynchronous active low; cars green, new period pending, request idle,
// period length 20, output register empty
`default_nettype none

module traffic_light_pedestrian_sequencer
  import tlps_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH = 8
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   cfg_we_i,
  input  wire logic [PeriodWidth-1:0] cfg_wdata_i,
  input  wire logic                   in_valid_i,
  output logic                        in_ready_o,
  input  wire logic                   button_pressed_i,
  output logic                        out_valid_o,
  input  wire logic                   out_ready_i,
  output logic                        car_green_o,
  output logic                        car_yellow_o,
  output logic                        car_red_o,
  output logic                        ped_green_o,
  output logic                        ped_yellow_o,
  output logic                        ped_red_o
);

  logic   accept;
  logic   free;
  lamps_t lamps_next;
  lamps_t lamps_reg;

  assign in_ready_o = free;
  assign accept     = in_valid_i && free;

  // tick sequencer
  tlps_seq #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .step_i     (accept),
    .press_i    (button_pressed_i),
    .lamps_o    (lamps_next)
  );

  // result register
  tlps_out u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (accept),
    .lamps_i    (lamps_next),
    .out_ready_i(out_ready_i),
    .out_valid_o(out_valid_o),
    .free_o     (free),
    .lamps_o    (lamps_reg)
  );

  assign car_green_o  = lamps_reg.car_green;
  assign car_yellow_o = lamps_reg.car_yellow;
  assign car_red_o    = lamps_reg.car_red;
  assign ped_green_o  = lamps_reg.ped_green;
  assign ped_yellow_o = lamps_reg.ped_yellow;
  assign ped_red_o    = lamps_reg.ped_red;

endmodule

`default_nettype wire

// File: sv/tlps_checker.sv
// port-level checks for the traffic light pedestrian sequencer, bound to the top level
`default_nettype none

module tlps_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_valid_i,
  input wire logic in_ready_o,
  input wire logic out_valid_o,
  input wire logic out_ready_i,
  input wire logic car_green_o,
  input wire logic car_yellow_o,
  input wire logic car_red_o,
  input wire logic ped_green_o,
  input wire logic ped_yellow_o,
  input wire logic ped_red_o
);

  // an accepted tick shows a word in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> out_valid_o)
    else $error("accepted tick produced no word");

  // a stalled word stays valid
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("stalled word dropped");

  // a stalled word keeps its lamps
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(car_green_o) && $stable(car_yellow_o)
      && $stable(car_red_o) && $stable(ped_green_o) && $stable(ped_yellow_o)
      && $stable(ped_red_o))
    else $error("stalled word changed");

  // car and pedestrian lamps agree
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (car_green_o == ped_red_o) && (car_red_o == ped_green_o)
      && (car_yellow_o == ped_yellow_o))
    else $error("car and pedestrian lamps disagree");

  // at most one car lamp lit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $countones({car_green_o, car_yellow_o, car_red_o}) <= 1)
    else $error("more than one car lamp lit");

endmodule

bind traffic_light_pedestrian_sequencer tlps_checker u_tlps_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .car_green_o (car_green_o),
  .car_yellow_o(car_yellow_o),
  .car_red_o   (car_red_o),
  .ped_green_o (ped_green_o),
  .ped_yellow_o(ped_yellow_o),
  .ped_red_o   (ped_red_o)
);

`default_nettype wire
